>>> rtl/cfnw_pkg.sv
// Shared types, codes and constant tables of the cube face neighbor walk unit.
// No dependencies; every other file of the block but cfnw_ram imports this package.
package cfnw_pkg;

  localparam int unsigned NumFaces    = 6;
  localparam int unsigned LedsPerFace = 9;
  localparam int unsigned StoreDepth  = NumFaces * LedsPerFace;
  localparam int unsigned ColorWidth  = 24;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] face_t;
  typedef logic [3:0] led_t;
  typedef logic [1:0] dir_t;
  typedef logic [2:0] dist_t;
  typedef logic [7:0] chan_t;
  typedef logic [5:0] addr_t;
  typedef logic [ColorWidth-1:0] color_t;

  // Request kinds.
  localparam kind_t KIND_WRITE    = 2'd0;
  localparam kind_t KIND_WALK     = 2'd1;
  localparam kind_t KIND_OPPOSITE = 2'd2;

  // Walk directions.
  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_RIGHT = 2'd1;
  localparam dir_t DIR_DOWN  = 2'd2;
  localparam dir_t DIR_LEFT  = 2'd3;

  // Neighbor face across each edge, per face and direction.
  localparam face_t EDGE_FACE [NumFaces][4] = '{
    '{3'd4, 3'd1, 3'd5, 3'd3},
    '{3'd4, 3'd2, 3'd5, 3'd0},
    '{3'd4, 3'd3, 3'd5, 3'd1},
    '{3'd4, 3'd0, 3'd5, 3'd2},
    '{3'd2, 3'd1, 3'd0, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd3}
  };

  // Clockwise quarter turns applied when crossing each edge.
  localparam logic [1:0] EDGE_TURN [NumFaces][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd3, 2'd0},
    '{2'd2, 2'd0, 2'd2, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  // LED remap after zero to three clockwise quarter turns.
  localparam led_t TURN_LED [4][LedsPerFace] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2},
    '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6}
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // request transfer this cycle
    logic step;      // advance the walk by one LED
    logic rd;        // read the color store at the current position
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_req;  // offered request produces a result
    logic cnt_zero;  // no steps left
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

>>> rtl/cfnw_req_if.sv
// Request channel of the cube face neighbor walk unit: valid, ready, payload.
// Depends on cfnw_pkg.
interface cfnw_req_if
  import cfnw_pkg::*;
;
  logic  valid;
  logic  ready;
  kind_t kind;
  face_t face;
  led_t  led;
  dir_t  dir;
  dist_t dist_req;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, kind, face, led, dir, dist_req, red, green, blue,
                  input ready);
  modport sink   (input valid, kind, face, led, dir, dist_req, red, green, blue,
                  output ready);
endinterface

>>> rtl/cfnw_rsp_if.sv
// Result channel of the cube face neighbor walk unit: valid, ready, payload.
// Depends on cfnw_pkg.
interface cfnw_rsp_if
  import cfnw_pkg::*;
;
  logic  valid;
  logic  ready;
  face_t new_face;
  led_t  new_led;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  modport source (output valid, new_face, new_led, out_red, out_green, out_blue,
                  input ready);
  modport sink   (input valid, new_face, new_led, out_red, out_green, out_blue,
                  output ready);
endinterface

>>> rtl/cfnw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfnw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cfnw_ctrl.sv
// Controller of the cube face neighbor walk unit: sequences accept, walk,
// store read and result hand-off. Depends on cfnw_pkg.
module cfnw_ctrl
  import cfnw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.walk_req) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.cnt_zero) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_LOAD;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_LOAD: begin
        // Hold the read data until the output register is free.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/cfnw_dp.sv
// Datapath of the cube face neighbor walk unit: position registers, step logic,
// color store with per-entry valid bits, output register.
// Depends on cfnw_pkg, cfnw_req_if, cfnw_rsp_if and cfnw_ram.
module cfnw_dp
  import cfnw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  cfnw_req_if.sink  req,
  cfnw_rsp_if.source rsp,
  input  cmd_t    cmd_i,
  output status_t status_o
);

  function automatic addr_t store_addr(face_t f, led_t l);
    return ({3'b000, f} << 3) + {3'b000, f} + {2'b00, l};
  endfunction

  // Walk state.
  face_t face_q, face_d;
  led_t  led_q, led_d;
  dir_t  dir_q, dir_d;
  dist_t cnt_q, cnt_d;
  logic  inrange_q, inrange_d;

  // Store read side.
  logic                  hit_q;
  color_t                rdata;
  logic [StoreDepth-1:0] vld_q;

  // Output register.
  logic  out_vld_q;
  face_t out_face_q;
  led_t  out_led_q;
  color_t out_color_q;

  logic  in_range;
  logic  wr_en;
  addr_t wr_addr;
  addr_t rd_addr;
  dir_t  ld_dir;
  dist_t ld_dist;
  logic  leaves;
  led_t  nxt_led;
  led_t  wrap_led;
  face_t step_face;
  led_t  step_led;

  assign in_range = (req.face < face_t'(NumFaces)) && (req.led < led_t'(LedsPerFace));
  assign wr_en    = cmd_i.accept && (req.kind == KIND_WRITE) && in_range;
  assign wr_addr  = store_addr(req.face, req.led);
  assign rd_addr  = store_addr(face_q, led_q);

  // The opposite-LED request picks its own direction and distance by position.
  always_comb begin
    ld_dir  = req.dir;
    ld_dist = req.dist_req;
    if (req.kind == KIND_OPPOSITE) begin
      priority if (req.led < 4'd3) begin
        ld_dir  = DIR_UP;
        ld_dist = 3'd4;
      end else if (req.led == 4'd3) begin
        ld_dir  = DIR_LEFT;
        ld_dist = 3'd4;
      end else if (req.led == 4'd4) begin
        ld_dir  = DIR_UP;
        ld_dist = 3'd6;
      end else if (req.led == 4'd5) begin
        ld_dir  = DIR_RIGHT;
        ld_dist = 3'd4;
      end else begin
        ld_dir  = DIR_DOWN;
        ld_dist = 3'd4;
      end
    end
  end

  // One step: either move within the face, or wrap to the opposite edge
  // position and remap it onto the neighbor face.
  always_comb begin
    unique case (dir_q)
      DIR_UP: begin
        leaves   = (led_q < 4'd3);
        nxt_led  = led_q - 4'd3;
        wrap_led = led_q + 4'd6;
      end
      DIR_RIGHT: begin
        leaves   = (led_q == 4'd2) || (led_q == 4'd5) || (led_q == 4'd8);
        nxt_led  = led_q + 4'd1;
        wrap_led = led_q - 4'd2;
      end
      DIR_DOWN: begin
        leaves   = (led_q > 4'd5);
        nxt_led  = led_q + 4'd3;
        wrap_led = led_q - 4'd6;
      end
      default: begin
        leaves   = (led_q == 4'd0) || (led_q == 4'd3) || (led_q == 4'd6);
        nxt_led  = led_q - 4'd1;
        wrap_led = led_q + 4'd2;
      end
    endcase
    if (leaves) begin
      step_face = EDGE_FACE[face_q][dir_q];
      step_led  = TURN_LED[EDGE_TURN[face_q][dir_q]][wrap_led];
    end else begin
      step_face = face_q;
      step_led  = nxt_led;
    end
  end

  always_comb begin
    face_d    = face_q;
    led_d     = led_q;
    dir_d     = dir_q;
    cnt_d     = cnt_q;
    inrange_d = inrange_q;
    if (cmd_i.accept) begin
      face_d    = req.face;
      led_d     = req.led;
      dir_d     = ld_dir;
      cnt_d     = in_range ? ld_dist : '0;
      inrange_d = in_range;
    end else if (cmd_i.step) begin
      face_d = step_face;
      led_d  = step_led;
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q    <= face_d;
    led_q     <= led_d;
    dir_q     <= dir_d;
    inrange_q <= inrange_d;
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      hit_q <= inrange_q && (rd_addr < addr_t'(StoreDepth)) && vld_q[rd_addr];
    end
  end

  cfnw_ram #(
    .Width(ColorWidth),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i({req.red, req.green, req.blue}),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_face_q  <= face_q;
      out_led_q   <= led_q;
      out_color_q <= hit_q ? rdata : '0;
    end
  end

  assign rsp.valid     = out_vld_q;
  assign rsp.new_face  = out_face_q;
  assign rsp.new_led   = out_led_q;
  assign rsp.out_red   = out_color_q[23:16];
  assign rsp.out_green = out_color_q[15:8];
  assign rsp.out_blue  = out_color_q[7:0];

  assign status_o.walk_req = (req.kind == KIND_WALK) || (req.kind == KIND_OPPOSITE);
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.out_free = !out_vld_q || rsp.ready;

endmodule

>>> rtl/cube_face_neighbor_walk_unit.sv
// Top level of the cube face neighbor walk unit.
// Depends on cfnw_pkg, cfnw_req_if, cfnw_rsp_if, cfnw_ctrl and cfnw_dp.
//
// Usage:
//   req_i carries one request per transfer: a color write (kind 0), a walk of
//   dist_req steps in direction dir (kind 1), or a walk to the opposite LED
//   (kind 2). Kind 3 is dropped. rsp_o carries one result per walk request:
//   the face and LED reached and the color stored there.
//   A color write is taken and gives no result. A walk occupies the unit
//   from the request transfer until the result is in the output register:
//   its steps (up to 7 for kind 1, 4 or 6 for kind 2) one after another
//   through the single step unit, then the store read, then the load of
//   the output register.
//   A new request is taken as soon as the previous one has reached the output
//   register, while its result may still wait there. If the receiver stalls
//   with a full output register, the next walk holds its result internally
//   and takes no further request until the register frees up.
//   Reset clears the color store to zero at once through per-entry valid
//   bits, empties the output register and returns the unit to idle.
module cube_face_neighbor_walk_unit
  import cfnw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cfnw_req_if.sink   req_i,
  cfnw_rsp_if.source rsp_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign req_i.ready = in_ready;

  cfnw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cfnw_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .rsp     (rsp_o),
    .cmd_i   (cmd),
    .status_o(status)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the cube face neighbor walk unit: color writes, walks and
// opposite-LED lookups against a local model of the color store and the cube edges.
// Depends on cfnw_pkg, cfnw_req_if, cfnw_rsp_if and cube_face_neighbor_walk_unit.
module testbench;
  import cfnw_pkg::*;

  localparam kind_t KIND_NONE = 2'd3;
  localparam int TAIL_ITEMS = 150;
  localparam int RANDOM_ITEMS = 1000;

  // Position offset of one step for up, right, down and left.
  localparam int STEP_OFS [4] = '{-3, 1, 3, -1};
  // Neighbor face plus six times the quarter turns, per face and direction.
  localparam int unsigned CROSS_CODE [6][4] = '{
    '{ 4,  1,  5,  3},
    '{10,  2, 23,  0},
    '{16,  3, 17,  1},
    '{22,  0, 11,  2},
    '{14, 19,  0,  9},
    '{ 0,  7, 14, 21}
  };
  localparam int unsigned QTURN_LED [4][9] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8},
    '{6, 3, 0, 7, 4, 1, 8, 5, 2},
    '{8, 7, 6, 5, 4, 3, 2, 1, 0},
    '{2, 5, 8, 1, 4, 7, 0, 3, 6}
  };

  typedef struct packed {
    kind_t  kind;
    face_t  face;
    led_t   led;
    dir_t   dir;
    dist_t  dist_req;
    color_t color;
  } req_item_t;

  typedef struct packed {
    face_t  face;
    led_t   led;
    color_t color;
  } walk_result_t;

  logic clk_i;
  logic rst_ni;

  cfnw_req_if req ();
  cfnw_rsp_if rsp ();

  cube_face_neighbor_walk_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  color_t       led_colors [StoreDepth];
  req_item_t    req_items_q [$];
  walk_result_t walk_results_q [$];
  req_item_t    next_item;
  walk_result_t got_result;
  walk_result_t want_result;
  logic         req_taken = 1'b0;
  int           errors = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           send_idle_pct = 10;
  int           recv_idle_pct = 10;

  function automatic int pick_idle_pct();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? 0 : ((r == 1) ? 8 : 30);
  endfunction

  // One step on the cube; the edge code gives the new face and the LED rotation.
  function automatic void take_step(inout face_t f, inout led_t l, input dir_t d);
    int off;
    int cur;
    int nxt;
    int wrapped;
    int unsigned code;
    off = STEP_OFS[d];
    cur = int'(l);
    nxt = cur + off;
    if (nxt < 0 || nxt >= 9 || (d[0] && (nxt / 3 != cur / 3))) begin
      code = CROSS_CODE[f][d];
      wrapped = (nxt - 3 * off + 9) % 9;
      f = face_t'(code % 6);
      l = led_t'(QTURN_LED[(code / 6) % 4][wrapped]);
    end else begin
      l = led_t'(nxt);
    end
  endfunction

  // Applies one accepted request to the store copy; returns 1 when it yields a result.
  function automatic bit walk_predict(input req_item_t it, output walk_result_t res);
    face_t f;
    led_t  l;
    dir_t  d;
    int    steps;
    bit    in_range;
    f = it.face;
    l = it.led;
    d = it.dir;
    steps = int'(it.dist_req);
    in_range = (it.face < NumFaces) && (it.led < LedsPerFace);
    res = '0;
    if (it.kind == KIND_NONE) return 1'b0;
    if (it.kind == KIND_WRITE) begin
      if (in_range) led_colors[it.face * LedsPerFace + it.led] = it.color;
      return 1'b0;
    end
    if (in_range) begin
      if (it.kind == KIND_OPPOSITE) begin
        steps = 4;
        if (l < 3) begin
          d = DIR_UP;
        end else if (l == 3) begin
          d = DIR_LEFT;
        end else if (l == 4) begin
          d = DIR_UP;
          steps = 6;
        end else if (l == 5) begin
          d = DIR_RIGHT;
        end else begin
          d = DIR_DOWN;
        end
      end
      for (int i = 0; i < steps; i++) take_step(f, l, d);
      res.color = led_colors[f * LedsPerFace + l];
    end
    res.face = f;
    res.led = l;
    return 1'b1;
  endfunction

  task automatic queue_item(kind_t k, face_t f, led_t l, dir_t d, dist_t n, color_t c);
    req_item_t it;
    it.kind = k;
    it.face = f;
    it.led = l;
    it.dir = d;
    it.dist_req = n;
    it.color = c;
    req_items_q.push_back(it);
  endtask

  task automatic flag_error(string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("cube_face_neighbor_walk_unit: mismatch");
    $finish;
  end

  // Request driver: holds valid until the transfer, inserts gaps only between items.
  always @(negedge clk_i) begin
    if (rst_ni && (!req.valid || req_taken)) begin
      if (send_gap > 0) begin
        req.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (req_items_q.size() > TAIL_ITEMS &&
                   $urandom_range(0, 99) < send_idle_pct) begin
        req.valid <= 1'b0;
        send_gap = $urandom_range(0, 13);
      end else if (req_items_q.size() != 0) begin
        next_item = req_items_q.pop_front();
        req.kind <= next_item.kind;
        req.face <= next_item.face;
        req.led <= next_item.led;
        req.dir <= next_item.dir;
        req.dist_req <= next_item.dist_req;
        req.red <= next_item.color[23:16];
        req.green <= next_item.color[15:8];
        req.blue <= next_item.color[7:0];
        req.valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) send_idle_pct = pick_idle_pct();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result receiver: back-pressure in bursts, none near the end of the run.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      rsp.ready <= 1'b0;
      recv_gap = recv_gap - 1;
    end else if (req_items_q.size() > TAIL_ITEMS &&
                 $urandom_range(0, 99) < recv_idle_pct) begin
      rsp.ready <= 1'b0;
      recv_gap = $urandom_range(0, 13);
    end else begin
      rsp.ready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) recv_idle_pct = pick_idle_pct();
  end

  // Monitor: predicts on each request transfer and checks each result transfer.
  always @(posedge clk_i) begin
    req_taken <= req.valid && req.ready;
    if (rst_ni && req.valid && req.ready) begin
      if (walk_predict({req.kind, req.face, req.led, req.dir, req.dist_req,
                        req.red, req.green, req.blue}, want_result))
        walk_results_q.push_back(want_result);
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (walk_results_q.size() == 0) begin
        flag_error($sformatf("result face %0d led %0d with nothing expected",
                             rsp.new_face, rsp.new_led));
      end else begin
        got_result = walk_results_q.pop_front();
        if (rsp.new_face !== got_result.face || rsp.new_led !== got_result.led ||
            rsp.out_red !== got_result.color[23:16] ||
            rsp.out_green !== got_result.color[15:8] ||
            rsp.out_blue !== got_result.color[7:0])
          flag_error($sformatf(
            "expected face %0d led %0d rgb %06h, got face %0d led %0d rgb %02h%02h%02h",
            got_result.face, got_result.led, got_result.color, rsp.new_face,
            rsp.new_led, rsp.out_red, rsp.out_green, rsp.out_blue));
      end
    end
  end

  initial begin
    int counted;
    int r;
    face_t f;
    led_t l;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.kind = KIND_WRITE;
    req.face = '0;
    req.led = '0;
    req.dir = DIR_UP;
    req.dist_req = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    rsp.ready = 1'b0;
    foreach (led_colors[i]) led_colors[i] = '0;

    // Directed part: field extremes, ignored writes, zero and full-length walks,
    // every opposite-LED class, out-of-range positions and the dropped kind.
    queue_item(KIND_WRITE, 3'd0, 4'd0, DIR_UP, 3'd0, 24'hFFFFFF);
    queue_item(KIND_WRITE, 3'd5, 4'd8, DIR_LEFT, 3'd7, 24'hA55AFF);
    queue_item(KIND_WRITE, 3'd3, 4'd4, DIR_RIGHT, 3'd3, 24'h123456);
    queue_item(KIND_WRITE, 3'd6, 4'd0, DIR_UP, 3'd0, 24'h00FF00);
    queue_item(KIND_WRITE, 3'd0, 4'd9, DIR_UP, 3'd0, 24'h0000FF);
    queue_item(KIND_WALK, 3'd0, 4'd0, DIR_UP, 3'd0, 24'h000000);
    for (int d = 0; d < 4; d++) queue_item(KIND_WALK, 3'd5, 4'd8, dir_t'(d), 3'd7, '0);
    for (int d = 0; d < 4; d++) queue_item(KIND_WALK, 3'd0, 4'd0, dir_t'(d), 3'd7, '0);
    queue_item(KIND_OPPOSITE, 3'd1, 4'd0, DIR_LEFT, 3'd7, '0);
    queue_item(KIND_OPPOSITE, 3'd2, 4'd3, DIR_UP, 3'd0, '0);
    queue_item(KIND_OPPOSITE, 3'd3, 4'd4, DIR_RIGHT, 3'd1, '0);
    queue_item(KIND_OPPOSITE, 3'd4, 4'd5, DIR_DOWN, 3'd2, '0);
    queue_item(KIND_OPPOSITE, 3'd5, 4'd8, DIR_UP, 3'd5, '0);
    queue_item(KIND_WALK, 3'd7, 4'd15, DIR_LEFT, 3'd7, 24'hFFFFFF);
    queue_item(KIND_OPPOSITE, 3'd2, 4'd12, DIR_UP, 3'd0, '0);
    queue_item(KIND_NONE, 3'd7, 4'd15, DIR_LEFT, 3'd7, 24'hFFFFFF);
    queue_item(KIND_WALK, 3'd2, 4'd4, DIR_DOWN, 3'd0, 24'hFFFFFF);

    // Random part: mostly in-range writes and walks, some out-of-range noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      f = face_t'($urandom_range(0, NumFaces - 1));
      l = led_t'($urandom_range(0, LedsPerFace - 1));
      if (r >= 85 && r < 93) begin
        f = face_t'($urandom_range(0, 7));
        l = led_t'($urandom_range(0, 15));
        if (f < NumFaces && l < LedsPerFace) begin
          if ($urandom_range(0, 1)) f = face_t'($urandom_range(6, 7));
          else l = led_t'($urandom_range(9, 15));
        end
      end
      queue_item((r < 35) ? KIND_WRITE : (r < 65) ? KIND_WALK : (r < 85) ? KIND_OPPOSITE :
                 (r < 93) ? kind_t'($urandom_range(0, 2)) : KIND_NONE,
                 f, l, dir_t'($urandom_range(0, 3)), dist_t'($urandom_range(0, 7)),
                 color_t'($urandom));
      if (r < 93) counted++;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_items_q.size() != 0 || req.valid) @(posedge clk_i);
    while (walk_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("cube_face_neighbor_walk_unit: match");
    end else begin
      $display("cube_face_neighbor_walk_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cfnw_pkg.sv
rtl/cfnw_req_if.sv
rtl/cfnw_rsp_if.sv
rtl/cfnw_ram.sv
rtl/cfnw_ctrl.sv
rtl/cfnw_dp.sv
rtl/cube_face_neighbor_walk_unit.sv
tb/testbench.sv
